FILE: hw/rtl/color_window_classifier_assert.svh
// Assertion macros used by the color window classifier checker.
`ifndef COLOR_WINDOW_CLASSIFIER_ASSERT_SVH
`define COLOR_WINDOW_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("color window classifier check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("color window classifier check failed");

`endif

FILE: hw/rtl/cwc_pkg.sv
// Shared constants, codes and types of the color window classifier.
package cwc_pkg;

    localparam int NUM_CLASSES      = 7;
    localparam int NUM_CHANNELS     = 4;
    localparam int LANE_BITS        = 16;
    localparam int REF_BITS         = NUM_CHANNELS * LANE_BITS;
    localparam int TOL_BITS         = 12;
    localparam int WTOL_BITS        = TOL_BITS + 1;
    localparam int EMPTY_WIDEN      = 40;
    localparam int CLASS_BITS       = 3;
    localparam int OUT_TDATA_BITS   = 8;
    localparam int CFG_DATA_BITS    = 64;
    localparam int CFG_ADDR_BITS    = 6;
    localparam int CFG_INDEX_LSB    = 3;
    localparam int CHANNEL_BITS_DEF = 16;

    typedef logic [CLASS_BITS-1:0] t_class;

    // Class codes, in priority order.
    localparam t_class CLS_RED     = 3'd0;
    localparam t_class CLS_GREEN   = 3'd1;
    localparam t_class CLS_BLUE    = 3'd2;
    localparam t_class CLS_YELLOW  = 3'd3;
    localparam t_class CLS_ORANGE  = 3'd4;
    localparam t_class CLS_WHITE   = 3'd5;
    localparam t_class CLS_EMPTY   = 3'd6;
    localparam t_class CLS_UNKNOWN = 3'd7;

    // Register indexes on the configuration port.
    typedef logic [2:0] t_reg_index;
    localparam t_reg_index REG_REF_RED    = 3'd0;
    localparam t_reg_index REG_REF_GREEN  = 3'd1;
    localparam t_reg_index REG_REF_BLUE   = 3'd2;
    localparam t_reg_index REG_REF_YELLOW = 3'd3;
    localparam t_reg_index REG_REF_ORANGE = 3'd4;
    localparam t_reg_index REG_REF_WHITE  = 3'd5;
    localparam t_reg_index REG_REF_EMPTY  = 3'd6;
    localparam t_reg_index REG_TOLERANCE  = 3'd7;

    // Per-class match flags moving from the lane stage to the merge stage.
    typedef struct packed {
        logic                   valid;
        logic [NUM_CLASSES-1:0] match;
    } t_match_word;

endpackage

FILE: hw/rtl/cwc_lane.sv
// One class lane: checks all four channels against one reference window.
module cwc_lane #(
    parameter int CHANNEL_BITS = cwc_pkg::CHANNEL_BITS_DEF
) (
    input  logic [cwc_pkg::REF_BITS-1:0]  i_sample,
    input  logic [cwc_pkg::REF_BITS-1:0]  i_ref,
    input  logic [cwc_pkg::WTOL_BITS-1:0] i_tol,
    output logic                          o_match
);
    import cwc_pkg::*;

    // Wide enough that neither channel plus tolerance can overflow.
    localparam int SUM_BITS =
        ((CHANNEL_BITS > WTOL_BITS) ? CHANNEL_BITS : WTOL_BITS) + 1;

    logic [NUM_CHANNELS-1:0] chan_ok;

    // Each channel must satisfy ref - tol <= meas <= ref + tol, rearranged
    // so that only unsigned additions appear.
    always_comb begin
        logic [SUM_BITS-1:0] meas;
        logic [SUM_BITS-1:0] refv;
        logic [SUM_BITS-1:0] tol;
        tol = SUM_BITS'(i_tol);
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            meas = SUM_BITS'(i_sample[ch*LANE_BITS +: CHANNEL_BITS]);
            refv = SUM_BITS'(i_ref[ch*LANE_BITS +: CHANNEL_BITS]);
            chan_ok[ch] = ((meas + tol) >= refv) && (meas <= (refv + tol));
        end
    end

    assign o_match = &chan_ok;

endmodule

FILE: hw/rtl/cwc_merge.sv
// Merge stage: picks the first matching class and holds the output word.
module cwc_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cwc_pkg::t_match_word       i_match,
    output logic                       o_ready,
    output logic                       o_valid,
    output cwc_pkg::t_class            o_class,
    input  logic                       i_ready
);
    import cwc_pkg::*;

    logic   r_valid;
    t_class r_class;
    t_class n_class;

    // Lowest class number wins; no match gives unknown.
    always_comb begin
        n_class = CLS_UNKNOWN;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (i_match.match[k]) begin
                n_class = CLASS_BITS'(k);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Output register: loads whenever it is empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_match.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_match.valid) begin
            r_class <= n_class;
        end
    end

    assign o_valid = r_valid;
    assign o_class = r_class;

endmodule

FILE: hw/rtl/color_window_classifier.sv
// Top level of the color window classifier: register file, class lanes, pipeline.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         i_s_tvalid / o_s_tready   red, green, blue, white levels
//  m_axis    out        o_m_tvalid / i_m_tready   color class
//  apb       in/out     psel, penable, pwrite     64-bit references, tolerance
//
// A word is accepted every cycle while the pipeline has room; its class is registered
// first in the lane result register behind the lane comparators, then in the merge register.
// The seven window lanes compare all channels in parallel, combinationally.
// Reset clears the pipeline valid flags and all configuration registers to zero.
// A stall on the output backs up through the two stages; input stays ready
// as long as either stage has room.
module color_window_classifier #(
    parameter int CHANNEL_BITS = cwc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: red_level[15:0], green_level[31:16], blue_level[47:32], white_level[63:48]
    input  logic [cwc_pkg::REF_BITS-1:0]       i_s_tdata,
    // Output stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: color_class[2:0], zero fill [7:3]
    output logic [cwc_pkg::OUT_TDATA_BITS-1:0] o_m_tdata,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwc_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [cwc_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [cwc_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import cwc_pkg::*;

    logic [REF_BITS-1:0]    r_ref [NUM_CLASSES];
    logic [TOL_BITS-1:0]    r_tol;
    t_reg_index             reg_index;
    logic                   cfg_write;
    logic [WTOL_BITS-1:0]   tol_std;
    logic [WTOL_BITS-1:0]   tol_empty;
    logic [NUM_CLASSES-1:0] lane_match;
    logic                   r_s1_valid;
    logic [NUM_CLASSES-1:0] r_s1_match;
    logic                   merge_ready;
    logic                   s1_ready;
    t_match_word            s1_word;
    t_class                 out_class;

    // Register decode: one 64-bit register per 8-byte slot.
    assign reg_index = paddr[CFG_ADDR_BITS-1:CFG_INDEX_LSB];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_ref[k] <= '0;
            end
            r_tol <= '0;
        end else if (cfg_write) begin
            if (reg_index == REG_TOLERANCE) begin
                r_tol <= pwdata[TOL_BITS-1:0];
            end else begin
                r_ref[reg_index] <= pwdata;
            end
        end
    end

    // Read back.
    always_comb begin
        case (reg_index)
            REG_REF_RED:    prdata = r_ref[REG_REF_RED];
            REG_REF_GREEN:  prdata = r_ref[REG_REF_GREEN];
            REG_REF_BLUE:   prdata = r_ref[REG_REF_BLUE];
            REG_REF_YELLOW: prdata = r_ref[REG_REF_YELLOW];
            REG_REF_ORANGE: prdata = r_ref[REG_REF_ORANGE];
            REG_REF_WHITE:  prdata = r_ref[REG_REF_WHITE];
            REG_REF_EMPTY:  prdata = r_ref[REG_REF_EMPTY];
            REG_TOLERANCE:  prdata = CFG_DATA_BITS'(r_tol);
            default:        prdata = '0;
        endcase
    end

    // The empty class uses a wider window than the colored classes.
    assign tol_std   = WTOL_BITS'(r_tol);
    assign tol_empty = WTOL_BITS'(r_tol) + WTOL_BITS'(EMPTY_WIDEN);

    // One window lane per reference class.
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_lane
        cwc_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .i_sample (i_s_tdata),
            .i_ref    (r_ref[g]),
            .i_tol    ((g == int'(CLS_EMPTY)) ? tol_empty : tol_std),
            .o_match  (lane_match[g])
        );
    end

    // Lane result register; it loads whenever it is empty or the merge stage can take its word.
    assign s1_ready   = !r_s1_valid || merge_ready;
    assign o_s_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_s_tvalid) begin
            r_s1_match <= lane_match;
        end
    end

    assign s1_word.valid = r_s1_valid;
    assign s1_word.match = r_s1_match;

    cwc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_match (s1_word),
        .o_ready (merge_ready),
        .o_valid (o_m_tvalid),
        .o_class (out_class),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = OUT_TDATA_BITS'(out_class);

endmodule

FILE: hw/rtl/cwc_checker.sv
// Port-level checker for the color window classifier, bound to the top level.
`include "color_window_classifier_assert.svh"

module cwc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // A stalled output word holds its class.
    `CWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // The padding above the class field is always zero on a valid word.
    `CWC_ASSERT_NOW(a_out_pad, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[7:3] == 5'd0)

    // With the output register empty the pipeline always has room.
    `CWC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    // After a word is accepted while the output register is empty, the output holds a valid word.
    `CWC_ASSERT_NOW(a_latency, i_clk, i_rst_n, i_s_tvalid && o_s_tready && !o_m_tvalid, ##2 o_m_tvalid)

endmodule

bind color_window_classifier cwc_checker u_cwc_checker (.*);

FILE: dv/tb_color_window_classifier.sv
// Self-checking testbench for the color window classifier: streams readings, predicts classes.
module tb_color_window_classifier;
    import cwc_pkg::*;

    localparam int CHAN_BITS         = CHANNEL_BITS_DEF;
    localparam int RANDOM_SETTINGS   = 6;
    localparam int ITEMS_PER_SETTING = 125;
    localparam int HOLD_CYCLES       = 60;
    localparam int STALL_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = 4;
    localparam int LEVEL_MAX         = (1 << CHAN_BITS) - 1;

    // Keeps a copy of the class references and the tolerance and predicts the class
    // of each accepted reading; results are checked in order of acceptance.
    class color_class_tracker;
        logic [REF_BITS-1:0] refs[NUM_CLASSES];
        int                  tolerance;
        t_class              pending_classes[$];
        int                  checked;
        int                  errors;
        int                  seen[1 << CLASS_BITS];

        function new();
            foreach (refs[c]) refs[c] = '0;
            tolerance = 0;
            checked   = 0;
            errors    = 0;
            foreach (seen[c]) seen[c] = 0;
        endfunction

        function void set_register(t_reg_index idx, logic [CFG_DATA_BITS-1:0] value);
            if (idx == REG_TOLERANCE) begin
                tolerance = int'(value[TOL_BITS-1:0]);
            end else begin
                refs[idx] = value[REF_BITS-1:0];
            end
        endfunction

        // First class, in priority order, whose window holds every channel.
        function t_class predict_class(logic [REF_BITS-1:0] reading);
            int level;
            int center;
            int width;
            bit hit;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                width = tolerance + ((t_class'(c) == CLS_EMPTY) ? EMPTY_WIDEN : 0);
                hit   = 1'b1;
                for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                    level  = int'(reading[ch*LANE_BITS +: CHAN_BITS]);
                    center = int'(refs[c][ch*LANE_BITS +: CHAN_BITS]);
                    if (level < center - width || level > center + width) hit = 1'b0;
                end
                if (hit) return t_class'(c);
            end
            return CLS_UNKNOWN;
        endfunction

        function void note_reading(logic [REF_BITS-1:0] reading);
            pending_classes.push_back(predict_class(reading));
        endfunction

        function void check_class(logic [OUT_TDATA_BITS-1:0] word);
            t_class got;
            t_class want;
            got = t_class'(word[CLASS_BITS-1:0]);
            if (pending_classes.size() == 0) begin
                $display("%0t: unexpected class word, expected none, actual %0d", $time, got);
                errors++;
            end else begin
                want = pending_classes.pop_front();
                checked++;
                if (got !== want) begin
                    $display("%0t: color_class mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end else begin
                    seen[want]++;
                end
            end
        endfunction

        function int pending();
            return pending_classes.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [REF_BITS-1:0]       i_s_tdata;
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_BITS-1:0]  paddr;
    logic [CFG_DATA_BITS-1:0]  pwdata;
    logic [CFG_DATA_BITS-1:0]  prdata;
    logic                      pready;

    color_class_tracker sb = new();
    bit                 traffic_gaps;
    bit                 hold_request;
    int                 settings;

    color_window_classifier u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // Pack four channel levels, red in the lowest lane.
    function automatic logic [REF_BITS-1:0] lanes(int r, int g, int b, int w);
        return {w[LANE_BITS-1:0], b[LANE_BITS-1:0], g[LANE_BITS-1:0], r[LANE_BITS-1:0]};
    endfunction

    // A reading near one class: mostly inside its window, often right on an edge
    // and sometimes one step past it.
    function automatic logic [REF_BITS-1:0] aim_reading(int c);
        logic [REF_BITS-1:0] r;
        int width;
        int center;
        int lvl;
        r     = '0;
        width = sb.tolerance + ((t_class'(c) == CLS_EMPTY) ? EMPTY_WIDEN : 0);
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            center = int'(sb.refs[c][ch*LANE_BITS +: LANE_BITS]);
            case ($urandom_range(0, 7))
                0:       lvl = center - width - int'($urandom_range(0, 1));
                1:       lvl = center + width + int'($urandom_range(0, 1));
                default: lvl = center - width + int'($urandom_range(0, 2 * width));
            endcase
            if (lvl < 0) lvl = 0;
            if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
            r[ch*LANE_BITS +: LANE_BITS] = lvl[LANE_BITS-1:0];
        end
        return r;
    endfunction

    // Lanes that favor the ends of the channel range.
    function automatic logic [REF_BITS-1:0] extreme_lanes();
        logic [REF_BITS-1:0] r;
        r = {$urandom, $urandom};
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            case ($urandom_range(0, 3))
                0:       r[ch*LANE_BITS +: LANE_BITS] = '0;
                1:       r[ch*LANE_BITS +: LANE_BITS] = '1;
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic logic [REF_BITS-1:0] random_reading();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 15) return aim_reading($urandom_range(0, NUM_CLASSES - 1));
        if (pick < 17) return {$urandom, $urandom};
        return extreme_lanes();
    endfunction

    // Offer one word and hold it until accepted, then maybe leave a gap.
    task automatic send_reading(logic [REF_BITS-1:0] reading);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= reading;
        do @(posedge i_clk); while (!o_s_tready);
        if (traffic_gaps && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= {$urandom, $urandom};
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Stop sending and let the pipeline empty before touching the registers.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle until pready, then the bus returns to idle.
    task automatic write_reg(t_reg_index idx, logic [CFG_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(idx) << CFG_INDEX_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    // Random references, some lanes at the range ends and some classes sharing
    // a reference so that priority decides.
    task automatic program_random_setting(int phase);
        logic [REF_BITS-1:0] prior;
        logic [CFG_DATA_BITS-1:0] tol_word;
        prior = extreme_lanes();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if ($urandom_range(0, 4) != 0) prior = extreme_lanes();
            write_reg(t_reg_index'(c), prior);
        end
        tol_word = {$urandom, $urandom};
        case (phase)
            0:       tol_word[TOL_BITS-1:0] = '0;
            1:       tol_word[TOL_BITS-1:0] = '1;
            3:       ;
            default: tol_word[TOL_BITS-1:0] = TOL_BITS'($urandom_range(0, 300));
        endcase
        write_reg(REG_TOLERANCE, tol_word);
        settings++;
    endtask

    // Note accepted readings and check accepted classes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_reading(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_class(o_m_tdata);
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin : sink
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (traffic_gaps && $urandom_range(0, 6) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Ends the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** color_window_classifier: FAILED **");
        $finish;
    end

    initial begin : stimulus
        traffic_gaps = 1'b1;
        hold_request = 1'b0;
        settings     = 1;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset references are all zero with no tolerance; the empty window is +-40.
        send_reading(lanes(0, 0, 0, 0));
        send_reading(lanes(1, 0, 0, 0));
        send_reading(lanes(40, 40, 40, 40));
        send_reading(lanes(0, 0, 0, 41));
        send_reading(lanes(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        settle();

        // Directed setting: red near zero, green near the top, yellow equal to blue.
        // The tolerance word carries junk above bit 11, which must be dropped.
        write_reg(REG_REF_RED,    lanes(10, 10, 10, 10));
        write_reg(REG_REF_GREEN,  lanes(65530, 65530, 65530, 65530));
        write_reg(REG_REF_BLUE,   lanes(1000, 2000, 3000, 4000));
        write_reg(REG_REF_YELLOW, lanes(1000, 2000, 3000, 4000));
        write_reg(REG_REF_ORANGE, lanes(5000, 6000, 7000, 8000));
        write_reg(REG_REF_WHITE,  lanes(20000, 21000, 22000, 23000));
        write_reg(REG_REF_EMPTY,  lanes(30000, 31000, 32000, 33000));
        write_reg(REG_TOLERANCE,  64'hFFFF_FFFF_FFFF_F064);
        settings++;
        send_reading(lanes(0, 0, 0, 0));
        send_reading(lanes(110, 0, 110, 0));
        send_reading(lanes(111, 10, 10, 10));
        send_reading(lanes(65535, 65535, 65535, 65535));
        send_reading(lanes(65430, 65535, 65430, 65530));
        send_reading(lanes(65429, 65530, 65530, 65530));
        send_reading(lanes(1100, 1900, 3000, 4100));
        send_reading(lanes(1000, 2000, 3101, 4000));
        send_reading(lanes(4900, 6100, 7000, 8000));
        send_reading(lanes(5000, 6000, 7000, 7899));
        send_reading(lanes(20000, 21000, 22000, 23000));
        send_reading(lanes(30140, 30860, 32000, 33000));
        send_reading(lanes(30141, 31000, 32000, 33000));
        send_reading(lanes(30000, 31000, 32000, 32859));
        send_reading(lanes(0, 65535, 0, 65535));

        // Random settings; the second one starts with a long output hold-off
        // and the last one runs at full rate.
        for (int p = 0; p < RANDOM_SETTINGS; p++) begin
            settle();
            program_random_setting(p);
            traffic_gaps = (p != RANDOM_SETTINGS - 1);
            if (p == 1) hold_request = 1'b1;
            repeat (ITEMS_PER_SETTING) send_reading(random_reading());
        end

        settle();
        $display("Checked %0d classifications over %0d register settings, with stalls on both sides.",
                 sb.checked, settings);
        $display("Correct results per class, red to unknown: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3],
                 sb.seen[4], sb.seen[5], sb.seen[6], sb.seen[7]);
        if (sb.errors == 0) begin
            $display("** color_window_classifier: PASSED **");
        end else begin
            $display("** color_window_classifier: FAILED **");
        end
        $finish;
    end

endmodule
